### hw/rtl/srds_pkg.sv
// ----------------------------------------------------------------------------
// srds_pkg: shared types and constants of the signed radix digit sequencer
// Holds the field widths, the radix saturation and the unit kind codes.
// ----------------------------------------------------------------------------
package srds_pkg;

  localparam int CODE_W       = 32;  // width of the input code
  localparam int MIND_W       = 5;   // width of the minimum digit count
  localparam int RADIX_W      = 5;   // width of the radix register
  localparam int DIGIT_W      = 4;   // width of one digit
  localparam int KIND_W       = 2;   // width of unit_kind
  localparam int SEG_BITS     = 8;   // dividend bits retired per divider stage
  localparam int SEGS         = CODE_W / SEG_BITS;  // divider stages per digit
  localparam int CAPACITY_DEF = 16;  // default number of units kept

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);

  typedef enum logic [KIND_W-1:0] {
    KIND_GAP   = 2'd0,
    KIND_DIGIT = 2'd1,
    KIND_SIGN  = 2'd2
  } unit_kind_t;

  // Clamp a raw radix write into the usable range.
  function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] raw);
    logic [RADIX_W-1:0] r;
    r = raw;
    if (raw < RADIX_MIN) begin
      r = RADIX_MIN;
    end else if (raw > RADIX_MAX) begin
      r = RADIX_MAX;
    end
    return r;
  endfunction

endpackage

### hw/rtl/signed_radix_digit_sequencer.sv
// ----------------------------------------------------------------------------
// signed_radix_digit_sequencer: signed code to radix digit unit stream
// Splits a signed 32-bit code into digits of the configured radix and emits
// sign, padding and digit units most significant first.
// ----------------------------------------------------------------------------
// Each accepted word (code, minimum digit count) yields between 1 and CAPACITY
// units on the result channel, one unit per cycle while out_ready is high; a
// word's unit count is at most CAPACITY, 16 by default, and the single result
// port sets the word rate. Inside, the word passes a front stage (sign and
// magnitude), SEGS*CAPACITY divider stages (each retires 8 dividend bits of
// one digit's division by the radix, four stages per digit) and a finish
// stage that works out the unit count. The pipeline takes a new word every
// cycle until the finished word in front of the sequencer has to wait; then
// all stages hold together. Units carry kind 0 for a zero digit or padding
// gap, 1 for a nonzero digit (digit field set) and 2 for the sign of a
// negative code; out_last marks the final unit. Only the CAPACITY least
// significant units are kept, so the high digits, padding and sign drop out
// when a sequence is longer. The radix register (reset 10) saturates writes
// into 2..16 and must only be written while the block is idle.
// ----------------------------------------------------------------------------
module signed_radix_digit_sequencer
  import srds_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [RADIX_W-1:0]   cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CODE_W-1:0] in_code,
  input  logic [MIND_W-1:0]    in_min_len,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KIND_W-1:0]    out_unit_kind,
  output logic [DIGIT_W-1:0]   out_digit,
  output logic                 out_last
);

  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int NST  = SEGS * CAPACITY;
  localparam int LW   = ((CNTW > MIND_W) ? CNTW : MIND_W) + 1;

  // Radix register: stores the saturated base used by every divider stage.
  logic [RADIX_W-1:0] radix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_we) begin
      radix_r <= sat_radix(cfg_wdata);
    end
  end

  // One enable advances the whole pipeline; it drops only when the finished
  // word cannot move into the sequencer.
  logic en;
  logic load_ok;
  logic fin_valid_r;

  assign en       = !fin_valid_r || load_ok;
  assign in_ready = en;

  // Front stage: split the code into sign and magnitude. The most negative
  // code comes out as 2^31, exact in 32 unsigned bits.
  logic               front_v_r;
  logic [CODE_W-1:0]  front_mag_r;
  logic               front_neg_r;
  logic [MIND_W-1:0]  front_mind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else if (en) begin
      front_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front_neg_r  <= in_code[CODE_W-1];
      front_mag_r  <= in_code[CODE_W-1] ? (~in_code + 1'b1) : in_code;
      front_mind_r <= in_min_len;
    end
  end

  // Divider chain: entry 0 is the front stage, entry g+1 the output of
  // divider stage g.
  logic                        st_v    [NST+1];
  logic [CODE_W-1:0]           st_work [NST+1];
  logic [DIGIT_W-1:0]          st_rem  [NST+1];
  logic [CAPACITY*DIGIT_W-1:0] st_digs [NST+1];
  logic [CNTW-1:0]             st_cnt  [NST+1];
  logic                        st_neg  [NST+1];
  logic [MIND_W-1:0]           st_mind [NST+1];

  assign st_v[0]    = front_v_r;
  assign st_work[0] = front_mag_r;
  assign st_rem[0]  = '0;
  assign st_digs[0] = '0;
  assign st_cnt[0]  = CNTW'(1);   // the least significant digit always counts
  assign st_neg[0]  = front_neg_r;
  assign st_mind[0] = front_mind_r;

  for (genvar g = 0; g < NST; g++) begin : g_div
    srds_div_step #(
      .CAPACITY  (CAPACITY),
      .DIGIT_IDX (g / SEGS),
      .SEG       (g % SEGS)
    ) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .radix    (radix_r),
      .v_in     (st_v[g]),
      .work_in  (st_work[g]),
      .rem_in   (st_rem[g]),
      .digs_in  (st_digs[g]),
      .cnt_in   (st_cnt[g]),
      .neg_in   (st_neg[g]),
      .mind_in  (st_mind[g]),
      .v_r      (st_v[g+1]),
      .work_r   (st_work[g+1]),
      .rem_r    (st_rem[g+1]),
      .digs_r   (st_digs[g+1]),
      .cnt_r    (st_cnt[g+1]),
      .neg_r    (st_neg[g+1]),
      .mind_r   (st_mind[g+1])
    );
  end

  // Finish stage: digit length is the larger of the digit count and the
  // minimum length, capped at CAPACITY; a nonzero leftover quotient means more
  // digits than fit, so the list is full. The sign takes one more place if
  // there is room. fin_top is the index of the first unit to emit.
  logic                        ovf;
  logic [LW-1:0]               cap_l, cnt_l, mind_l, len_l, n_l;
  logic [CNTW-1:0]             fin_lc_nxt, fin_lc_r;
  logic [IDXW-1:0]             fin_top_nxt, fin_top_r;
  logic [CAPACITY*DIGIT_W-1:0] fin_digs_r;
  logic                        fin_neg_r;

  always_comb begin
    ovf    = (st_work[NST] != '0);
    cap_l  = LW'(CAPACITY);
    cnt_l  = LW'(st_cnt[NST]);
    mind_l = LW'(st_mind[NST]);
    len_l  = (mind_l > cnt_l) ? mind_l : cnt_l;
    if (ovf || len_l > cap_l) begin
      len_l = cap_l;
    end
    n_l = len_l + LW'(st_neg[NST]);
    if (n_l > cap_l) begin
      n_l = cap_l;
    end
    fin_lc_nxt  = CNTW'(len_l);
    fin_top_nxt = IDXW'(n_l - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (en) begin
      fin_valid_r <= st_v[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_digs_r <= st_digs[NST];
      fin_lc_r   <= fin_lc_nxt;
      fin_neg_r  <= st_neg[NST];
      fin_top_r  <= fin_top_nxt;
    end
  end

  // Sequencer: walk the finished word from its top unit down to unit zero.
  srds_emitter #(
    .CAPACITY (CAPACITY)
  ) u_emitter (
    .clk           (clk),
    .rst_n         (rst_n),
    .fin_valid     (fin_valid_r),
    .load_ok       (load_ok),
    .fin_digs      (fin_digs_r),
    .fin_lc        (fin_lc_r),
    .fin_neg       (fin_neg_r),
    .fin_top       (fin_top_r),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_unit_kind (out_unit_kind),
    .out_digit     (out_digit),
    .out_last      (out_last)
  );

endmodule

### hw/rtl/srds_div_step.sv
// ----------------------------------------------------------------------------
// srds_div_step: one stage of the digit divider pipeline
// Retires SEG_BITS dividend bits of one digit's division by the radix; the
// last stage of a digit stores the remainder as that digit.
// ----------------------------------------------------------------------------
module srds_div_step
  import srds_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int DIGIT_IDX = 0,
  parameter int SEG       = 0
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic [RADIX_W-1:0]                   radix,
  input  logic                                 v_in,
  input  logic [CODE_W-1:0]                    work_in,
  input  logic [DIGIT_W-1:0]                   rem_in,
  input  logic [CAPACITY*DIGIT_W-1:0]          digs_in,
  input  logic [$clog2(CAPACITY+1)-1:0]        cnt_in,
  input  logic                                 neg_in,
  input  logic [MIND_W-1:0]                    mind_in,
  output logic                                 v_r,
  output logic [CODE_W-1:0]                    work_r,
  output logic [DIGIT_W-1:0]                   rem_r,
  output logic [CAPACITY*DIGIT_W-1:0]          digs_r,
  output logic [$clog2(CAPACITY+1)-1:0]        cnt_r,
  output logic                                 neg_r,
  output logic [MIND_W-1:0]                    mind_r
);

  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int HI   = CODE_W - 1 - SEG * SEG_BITS;

  logic [CODE_W-1:0]           work_nxt;
  logic [DIGIT_W-1:0]          rem_nxt;
  logic [CAPACITY*DIGIT_W-1:0] digs_nxt;
  logic [CNTW-1:0]             cnt_nxt;
  logic [DIGIT_W:0]            trial;

  always_comb begin
    work_nxt = work_in;
    rem_nxt  = rem_in;
    digs_nxt = digs_in;
    cnt_nxt  = cnt_in;
    trial    = '0;
    // count this digit when what is left to divide is still nonzero
    if (SEG == 0 && DIGIT_IDX > 0 && work_in != '0) begin
      cnt_nxt = CNTW'(cnt_in + 1'b1);
    end
    // restoring long division, one quotient bit per step
    for (int i = 0; i < SEG_BITS; i++) begin
      trial = {rem_nxt, work_nxt[HI-i]};
      if (trial >= radix) begin
        work_nxt[HI-i] = 1'b1;
        rem_nxt        = DIGIT_W'(trial - radix);
      end else begin
        work_nxt[HI-i] = 1'b0;
        rem_nxt        = trial[DIGIT_W-1:0];
      end
    end
    if (SEG == SEGS - 1) begin
      digs_nxt[DIGIT_IDX*DIGIT_W +: DIGIT_W] = rem_nxt;
      rem_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      work_r <= work_nxt;
      rem_r  <= rem_nxt;
      digs_r <= digs_nxt;
      cnt_r  <= cnt_nxt;
      neg_r  <= neg_in;
      mind_r <= mind_in;
    end
  end

endmodule

### hw/rtl/srds_emitter.sv
// ----------------------------------------------------------------------------
// srds_emitter: unit sequencer on the result channel
// Holds one finished word and presents its units most significant first.
// ----------------------------------------------------------------------------
module srds_emitter
  import srds_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  fin_valid,
  output logic                                  load_ok,
  input  logic [CAPACITY*DIGIT_W-1:0]           fin_digs,
  input  logic [$clog2(CAPACITY+1)-1:0]         fin_lc,
  input  logic                                  fin_neg,
  input  logic [((CAPACITY>1)?$clog2(CAPACITY):1)-1:0] fin_top,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic [KIND_W-1:0]                     out_unit_kind,
  output logic [DIGIT_W-1:0]                    out_digit,
  output logic                                  out_last
);

  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                        out_valid_r, out_valid_nxt;
  logic [IDXW-1:0]             pos_r, pos_nxt;
  logic [CAPACITY*DIGIT_W-1:0] digs_r, digs_nxt;
  logic [CNTW-1:0]             lc_r, lc_nxt;
  logic                        neg_r, neg_nxt;
  logic                        take, load, at_sign;
  logic [DIGIT_W-1:0]          cur_digit;
  unit_kind_t                  kind;

  assign take     = out_valid_r && out_ready;
  assign load_ok  = !out_valid_r || (take && out_last);
  assign load     = fin_valid && load_ok;

  assign at_sign   = neg_r && (CNTW'(pos_r) == lc_r);
  assign cur_digit = digs_r[pos_r*DIGIT_W +: DIGIT_W];

  always_comb begin
    if (at_sign) begin
      kind = KIND_SIGN;
    end else if (cur_digit != '0) begin
      kind = KIND_DIGIT;
    end else begin
      kind = KIND_GAP;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_unit_kind = kind;
  assign out_digit     = at_sign ? '0 : cur_digit;
  assign out_last      = (pos_r == '0);

  always_comb begin
    out_valid_nxt = out_valid_r;
    pos_nxt       = pos_r;
    digs_nxt      = digs_r;
    lc_nxt        = lc_r;
    neg_nxt       = neg_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      pos_nxt       = fin_top;
      digs_nxt      = fin_digs;
      lc_nxt        = fin_lc;
      neg_nxt       = fin_neg;
    end else if (take) begin
      if (out_last) begin
        out_valid_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    digs_r <= digs_nxt;
    lc_r   <= lc_nxt;
    neg_r  <= neg_nxt;
  end

`ifndef SYNTHESIS
  // a unit taken that is not the last keeps the word on the channel
  a_seq_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !out_last) |=> (out_valid_r && pos_r == $past(pos_r) - 1'b1))
    else $error("word ended before its last unit");

  // a stalled unit keeps its place in the sequence
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(pos_r))
    else $error("unit position moved during a stall");

  // a fresh word starts at its top unit
  a_load_top: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (out_valid_r && pos_r == $past(fin_top)))
    else $error("word loaded at the wrong unit");

  // the sign unit never follows another unit of the same word
  a_sign_first: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !out_last) |=> (kind != KIND_SIGN))
    else $error("sign unit out of place");
`endif

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the signed radix digit sequencer
// Sends signed codes with random spacing and random result stalls, expands
// each accepted code into its expected unit stream in the configured radix,
// and checks every unit on the result channel against it, in order.
// ----------------------------------------------------------------------------
module tb
  import srds_pkg::*;
;

  localparam int UNITS_MAX      = CAPACITY_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  // Settle wait: the divider stage count plus a margin.
  localparam int SETTLE_CYCLES  = SEGS * UNITS_MAX + 40;
  localparam int PHASES         = 10;
  localparam int WORDS_PER_PHASE = 20;

  typedef struct {
    unit_kind_t         kind;
    logic [DIGIT_W-1:0] digit;
    logic               last;
  } unit_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [RADIX_W-1:0]       cfg_wdata;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [CODE_W-1:0] in_code;
  logic [MIND_W-1:0]        in_min_len;
  logic                     out_valid;
  logic                     out_ready;
  logic [KIND_W-1:0]        out_unit_kind;
  logic [DIGIT_W-1:0]       out_digit;
  logic                     out_last;

  // Expected units, oldest first, across all words in flight.
  unit_t              pending_units[$];
  // Radix the block holds, as last written.
  logic [RADIX_W-1:0] radix_shadow;
  int                 mismatch_count;
  int                 idle_cycles;
  // Per-side switches for the random gaps and stalls.
  bit                 in_idle_on;
  bit                 out_idle_on;

  signed_radix_digit_sequencer i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_code       (in_code),
    .in_min_len    (in_min_len),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_unit_kind (out_unit_kind),
    .out_digit     (out_digit),
    .out_last      (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Predictor: split the magnitude into digits least significant first, keep
  // at most UNITS_MAX units, then queue them most significant first.
  // --------------------------------------------------------------------------
  function automatic void expand_code(input logic [CODE_W-1:0] code,
                                      input logic [MIND_W-1:0] min_len,
                                      input logic [RADIX_W-1:0] radix_raw);
    logic [CODE_W-1:0] mag;
    int unsigned       base;
    int unsigned       rem;
    int unsigned       n_digits;
    bit                negative;
    unit_t             low_first[$];
    unit_t             u;
    // Saturate the radix into 2..16.
    if (radix_raw < 2) begin
      base = 2;
    end else if (radix_raw > 16) begin
      base = 16;
    end else begin
      base = radix_raw;
    end
    negative = code[CODE_W-1];
    // Two's complement negate; the most negative code gives 2^31 exactly.
    mag = negative ? (~code + 1'b1) : code;
    n_digits = 0;
    do begin
      rem = mag % base;
      mag = mag / base;
      if (low_first.size() < UNITS_MAX) begin
        u.kind  = (rem == 0) ? KIND_GAP : KIND_DIGIT;
        u.digit = DIGIT_W'(rem);
        u.last  = 1'b0;
        low_first.push_back(u);
      end
      n_digits++;
    end while (mag != 0);
    // Pad with zero gaps up to the minimum length; drop what does not fit.
    while (n_digits < min_len) begin
      if (low_first.size() < UNITS_MAX) begin
        u.kind  = KIND_GAP;
        u.digit = '0;
        u.last  = 1'b0;
        low_first.push_back(u);
      end
      n_digits++;
    end
    if (negative && low_first.size() < UNITS_MAX) begin
      u.kind  = KIND_SIGN;
      u.digit = '0;
      u.last  = 1'b0;
      low_first.push_back(u);
    end
    // Emit most significant first; the least significant digit closes it.
    for (int k = low_first.size() - 1; k >= 0; k--) begin
      u      = low_first[k];
      u.last = (k == 0);
      pending_units.push_back(u);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Present one word and hold it until accepted. Valid is only dropped when a
  // gap follows, so back-to-back words keep it high without a glitch.
  task automatic send_code(input logic signed [CODE_W-1:0] code,
                           input logic [MIND_W-1:0] min_len);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_code    <= code;
    in_min_len <= min_len;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    expand_code(code, min_len, radix_shadow);
  endtask

  // Drop valid and wait until every expected unit has come back.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_units.size() != 0) @(posedge clk);
  endtask

  // Write the radix register; only called with the block idle.
  task automatic set_radix(input logic [RADIX_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    radix_shadow  = value;
  endtask

  function automatic logic signed [CODE_W-1:0] pick_code();
    logic signed [CODE_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 300);
      2: v = -$signed(CODE_W'($urandom_range(1, 300)));
      3: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = '0;
          default: v = -1;
        endcase
      end
      default: begin
        // Spread magnitudes over every digit count.
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) begin
          v = -v;
        end
      end
    endcase
    return v;
  endfunction

  function automatic logic [MIND_W-1:0] pick_min_len();
    return ($urandom_range(0, 9) == 0) ? MIND_W'($urandom_range(17, 31))
                                       : MIND_W'($urandom_range(0, 16));
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset radix of ten: zero, one digit, both signs, the code extremes, and
  // padding from none up past the unit capacity.
  task automatic test_reset_radix();
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    radix_shadow = RADIX_RESET;
    send_code(0, 0);
    send_code(0, 31);
    send_code(1, 0);
    send_code(-1, 0);
    send_code(9, 3);
    send_code(10, 0);
    send_code(32'sh7fff_ffff, 0);
    send_code(32'sh8000_0000, 0);
    send_code(-305, 16);
    wait_drain();
  endtask

  // Radix writes at and beyond both ends; the most negative code overflows
  // capacity in base two, so the high digits and sign drop out.
  task automatic test_radix_limits();
    logic [RADIX_W-1:0] radix_list[4];
    radix_list = '{RADIX_W'(0), RADIX_W'(31), RADIX_MIN, RADIX_MAX};
    foreach (radix_list[i]) begin
      set_radix(radix_list[i]);
      send_code(32'sh8000_0000, 0);
      send_code(32'sh7fff_ffff, 16);
      send_code(-6, 20);
      wait_drain();
    end
  endtask

  // Random words in phases, each with its own radix and its own idling mix.
  task automatic test_random_phases();
    logic [RADIX_W-1:0] next_radix;
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        next_radix = RADIX_W'(1);
      end else if (p == 1) begin
        next_radix = RADIX_W'(17);
      end else if ($urandom_range(0, 3) == 0) begin
        next_radix = RADIX_W'($urandom_range(0, 31));
      end else begin
        next_radix = RADIX_W'($urandom_range(2, 16));
      end
      set_radix(next_radix);
      // Run one phase flat out, the rest with a random mix of gaps and stalls.
      in_idle_on  = (p != 2) && ($urandom_range(0, 2) != 0);
      out_idle_on = (p != 2) && ($urandom_range(0, 2) != 0);
      for (int w = 0; w < WORDS_PER_PHASE; w++) begin
        send_code(pick_code(), pick_min_len());
      end
      wait_drain();
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: stall for a random count per unit, then hold ready until
  // a unit is taken.
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = out_idle_on ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid === 1'b1 && out_ready === 1'b1)) @(posedge clk);
    end
  end

  // Compare each taken unit with the oldest expectation, field by field.
  always @(posedge clk) begin
    unit_t want;
    if (rst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_units.size() == 0) begin
        $display("%0t: unit with none expected: kind %0d digit %0d last %0d",
                 $time, out_unit_kind, out_digit, out_last);
        mismatch_count++;
      end else begin
        want = pending_units.pop_front();
        if (out_unit_kind !== want.kind) begin
          $display("%0t: unit_kind expected %0d actual %0d",
                   $time, want.kind, out_unit_kind);
          mismatch_count++;
        end
        if (out_digit !== want.digit) begin
          $display("%0t: digit expected %0d actual %0d", $time, want.digit, out_digit);
          mismatch_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last expected %0d actual %0d", $time, want.last, out_last);
          mismatch_count++;
        end
      end
    end
  end

  // Abort when no word moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_ready === 1'b1) ||
        (out_valid === 1'b1 && out_ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset once, run the tests in turn, settle, report.
  // --------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_code        = '0;
    in_min_len     = '0;
    mismatch_count = 0;
    idle_cycles    = 0;
    in_idle_on     = 1'b1;
    out_idle_on    = 1'b1;
    radix_shadow   = RADIX_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_radix();
    test_radix_limits();
    test_random_phases();

    // Catch any unit the block emits beyond what was expected.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
